@@ src/q24alu_pkg.sv @@
// Shared types, constants and saturating pack function for the Q24.8 ALU.
// No dependencies; used by the ALU top level.
package q24alu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DivBits  = WordBits + FracBits;
  localparam int unsigned ProdBits = 2 * WordBits;
  localparam int unsigned MagBits  = ProdBits - FracBits + 1;
  localparam int unsigned NumStg   = DivBits + 2;
  localparam int unsigned LastStg  = NumStg - 1;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpCmp     = 4'd4,
    OpMin     = 4'd5,
    OpMax     = 4'd6,
    OpInc     = 4'd7,
    OpDec     = 4'd8,
    OpIntPart = 4'd9,
    OpFromInt = 4'd10
  } op_e;

  localparam logic [WordBits-1:0] MaxVal = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinVal = {1'b1, {(WordBits-1){1'b0}}};

  typedef struct packed {
    op_e                   op;
    logic                  neg;
    logic [WordBits-1:0]   res;
    logic                  gt;
    logic                  lt;
    logic                  eq;
    logic                  sat;
    logic                  dz;
    logic [WordBits-1:0]   amag;
    logic [WordBits-1:0]   bmag;
    logic [ProdBits-1:0]   prod;
    logic [WordBits:0]     rem;
    logic [DivBits-1:0]    quo;
  } stage_t;

  // returns {saturated, value}
  function automatic logic [WordBits:0] sat_pack(input logic neg,
                                                 input logic [MagBits-1:0] mag);
    logic [MagBits-1:0] lim;
    logic [WordBits-1:0] low;
    lim = MagBits'(MaxVal) + MagBits'(neg);
    low = mag[WordBits-1:0];
    if (mag > lim) begin
      sat_pack = {1'b1, (neg ? MinVal : MaxVal)};
    end else begin
      sat_pack = {1'b0, (neg ? (~low + 1'b1) : low)};
    end
  endfunction

endpackage

@@ src/q24_8_fixed_point_alu_top.sv @@
// Q24.8 fixed-point ALU, fully pipelined top level.
// Depends on q24alu_pkg.
//
// Accepts one request per cycle while in_stall_o is low and returns each result
// in request order. The depth is set by the restoring divider, which
// retires one quotient bit per stage over 40 stages plus a rounding stage;
// the 32x32 multiply sits in stage 1 and its rounding in stage 2. A stall on
// the output freezes the whole pipeline, so in_stall_o rises only while a
// finished result waits at the output.
module q24_8_fixed_point_alu_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] result_o,
  output logic        greater_o,
  output logic        less_o,
  output logic        equal_o,
  output logic        saturated_o,
  output logic        divide_by_zero_o
);

  localparam int unsigned W = q24alu_pkg::WordBits;
  localparam int unsigned F = q24alu_pkg::FracBits;
  localparam int unsigned L = q24alu_pkg::LastStg;

  q24alu_pkg::stage_t in_d;
  q24alu_pkg::stage_t stg_d [q24alu_pkg::NumStg];
  q24alu_pkg::stage_t stg_q [q24alu_pkg::NumStg];
  logic [q24alu_pkg::NumStg-1:0] vld_q;
  logic adv;

  assign adv        = !(vld_q[L] && out_stall_i);
  assign in_stall_o = !adv;

  logic [W:0] sum_w;
  logic [W:0] dif_w;
  logic [W-1:0] amag_w;
  logic [W-1:0] bmag_w;
  logic [W-1:0] ipart_w;
  logic a_lt_b;

  always_comb begin
    logic [W:0] pk;
    amag_w  = operand_a_i[W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    bmag_w  = operand_b_i[W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    sum_w   = {operand_a_i[W-1], operand_a_i} + {operand_b_i[W-1], operand_b_i};
    dif_w   = {operand_a_i[W-1], operand_a_i} - {operand_b_i[W-1], operand_b_i};
    a_lt_b  = operand_a_i < operand_b_i;
    ipart_w = amag_w >> F;
    pk      = '0;

    in_d      = '0;
    in_d.op   = q24alu_pkg::op_e'(op_i);
    in_d.amag = amag_w;
    in_d.bmag = bmag_w;
    in_d.quo  = {amag_w, {F{1'b0}}};
    in_d.neg  = operand_a_i[W-1] ^ operand_b_i[W-1];

    unique case (op_i)
      q24alu_pkg::OpAdd: begin
        in_d.sat = sum_w[W] != sum_w[W-1];
        in_d.res = in_d.sat ? (sum_w[W] ? q24alu_pkg::MinVal : q24alu_pkg::MaxVal)
                            : sum_w[W-1:0];
      end
      q24alu_pkg::OpSub: begin
        in_d.sat = dif_w[W] != dif_w[W-1];
        in_d.res = in_d.sat ? (dif_w[W] ? q24alu_pkg::MinVal : q24alu_pkg::MaxVal)
                            : dif_w[W-1:0];
      end
      q24alu_pkg::OpMul: begin
      end
      q24alu_pkg::OpDiv: begin
        if (operand_b_i == '0) begin
          in_d.dz  = 1'b1;
          in_d.sat = 1'b1;
          in_d.res = operand_a_i[W-1] ? q24alu_pkg::MinVal : q24alu_pkg::MaxVal;
        end
      end
      q24alu_pkg::OpCmp: begin
        in_d.gt = !a_lt_b && (operand_a_i != operand_b_i);
        in_d.lt = a_lt_b;
        in_d.eq = operand_a_i == operand_b_i;
      end
      q24alu_pkg::OpMin: in_d.res = a_lt_b ? operand_a_i : operand_b_i;
      q24alu_pkg::OpMax: begin
        in_d.res = (!a_lt_b && (operand_a_i != operand_b_i)) ? operand_a_i : operand_b_i;
      end
      q24alu_pkg::OpInc: begin
        in_d.sat = operand_a_i == q24alu_pkg::MaxVal;
        in_d.res = in_d.sat ? q24alu_pkg::MaxVal : operand_a_i + 1'b1;
      end
      q24alu_pkg::OpDec: begin
        in_d.sat = operand_a_i == q24alu_pkg::MinVal;
        in_d.res = in_d.sat ? q24alu_pkg::MinVal : operand_a_i - 1'b1;
      end
      q24alu_pkg::OpIntPart: begin
        in_d.res = operand_a_i[W-1] ? (~ipart_w + 1'b1) : ipart_w;
      end
      q24alu_pkg::OpFromInt: begin
        pk = q24alu_pkg::sat_pack(operand_a_i[W-1],
                                  q24alu_pkg::MagBits'({amag_w, {F{1'b0}}}));
        in_d.sat = pk[W];
        in_d.res = pk[W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic [W:0] r2;
    logic [W:0] pk;
    logic [q24alu_pkg::ProdBits-1:0] rnd;
    logic [q24alu_pkg::DivBits:0] qr;
    r2  = '0;
    pk  = '0;
    rnd = '0;
    qr  = '0;
    stg_d[0] = in_d;
    for (int unsigned k = 1; k < q24alu_pkg::NumStg; k++) begin
      stg_d[k] = stg_q[k-1];
      if (k <= q24alu_pkg::DivBits) begin
        r2 = {stg_q[k-1].rem[W-1:0], stg_q[k-1].quo[q24alu_pkg::DivBits-1]};
        if (r2 >= {1'b0, stg_q[k-1].bmag}) begin
          stg_d[k].rem = r2 - {1'b0, stg_q[k-1].bmag};
          stg_d[k].quo = {stg_q[k-1].quo[q24alu_pkg::DivBits-2:0], 1'b1};
        end else begin
          stg_d[k].rem = r2;
          stg_d[k].quo = {stg_q[k-1].quo[q24alu_pkg::DivBits-2:0], 1'b0};
        end
      end
      if (k == 1) begin
        stg_d[k].prod = q24alu_pkg::ProdBits'(stg_q[k-1].amag) *
                        q24alu_pkg::ProdBits'(stg_q[k-1].bmag);
      end
      if (k == 2 && stg_q[k-1].op == q24alu_pkg::OpMul) begin
        rnd = (stg_q[k-1].prod + (q24alu_pkg::ProdBits'(1) << (F - 1))) >> F;
        pk  = q24alu_pkg::sat_pack(stg_q[k-1].neg, q24alu_pkg::MagBits'(rnd));
        stg_d[k].sat = pk[W];
        stg_d[k].res = pk[W-1:0];
      end
      if (k == L && stg_q[k-1].op == q24alu_pkg::OpDiv && !stg_q[k-1].dz) begin
        qr = {1'b0, stg_q[k-1].quo} +
             (q24alu_pkg::DivBits+1)'({stg_q[k-1].rem, 1'b0} >= {2'b00, stg_q[k-1].bmag});
        pk = q24alu_pkg::sat_pack(stg_q[k-1].neg, q24alu_pkg::MagBits'(qr));
        stg_d[k].sat = pk[W];
        stg_d[k].res = pk[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[q24alu_pkg::NumStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q <= stg_d;
    end
  end

  assign out_valid_o      = vld_q[L];
  assign result_o         = stg_q[L].res;
  assign greater_o        = stg_q[L].gt;
  assign less_o           = stg_q[L].lt;
  assign equal_o          = stg_q[L].eq;
  assign saturated_o      = stg_q[L].sat;
  assign divide_by_zero_o = stg_q[L].dz;

endmodule

@@ src/q24alu_checker.sv @@
// Port-level checker for the Q24.8 ALU, bound to the top level.
// Depends on q24_8_fixed_point_alu_top ports only.
module q24alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_o,
  input logic        greater_o,
  input logic        less_o,
  input logic        equal_o,
  input logic        saturated_o,
  input logic        divide_by_zero_o
);

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("stall without held result");

  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> saturated_o && !greater_o && !less_o && !equal_o)
    else $error("divide by zero flags wrong");

  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({greater_o, less_o, equal_o}) <= 1)
    else $error("compare flags not exclusive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("stalled result changed");

endmodule

bind q24_8_fixed_point_alu_top q24alu_checker u_q24alu_checker (.*);
